@@ rtl/hcr_pkg.sv @@
// Shared constants, types and helpers of the Harris corner response block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
package hcr_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int HEIGHT_LIM = 1024;
  localparam int PIXEL_BITS = 8;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 10;
  localparam int DIM_W      = 11;
  localparam int RAD_W      = 2;
  localparam int K_W        = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int RESP_W     = 54;
  localparam int RING_ROWS  = 7;
  localparam int RING_W     = 3;
  localparam int GRAD_W     = 11;
  localparam int PROD_W     = 21;
  localparam int SQ_SUM_W   = 26;
  localparam int XY_SUM_W   = 27;
  localparam int MUL_IN_W   = 27;
  localparam int MUL_OUT_W  = 2 * MUL_IN_W;
  localparam int Q_W        = 56;
  localparam int KLO_W      = MUL_IN_W + K_W;
  localparam int QDEPTH     = 4;
  localparam int QAW        = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HARRIS_K,
    CFG_WINDOW_RADIUS,
    CFG_IMAGE_WIDTH,
    CFG_IMAGE_HEIGHT
  } cfg_idx_t;

  // One classified pixel request passed from front to back.
  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic [COL_W-1:0]      x;
    logic [ROW_W-1:0]      y;
    logic [1:0]            r3;
    logic [RING_W-1:0]     r7;
    logic [RAD_W-1:0]      rad;
    logic                  grad;
    logic                  resp;
    logic                  last;
  } hcr_ent_t;

  typedef enum logic [3:0] {
    B_IDLE, B_PIX, B_PWAIT, B_GRAD, B_PROD, B_SUM, B_SWAIT,
    B_M1, B_M2, B_M3, B_M4, B_M5, B_M6, B_M7, B_M8, B_OUT
  } hcr_bstate_t;

  function automatic logic [1:0] mod3_inc(input logic [1:0] v);
    return (v == 2'd2) ? 2'd0 : v + 2'd1;
  endfunction

  function automatic logic [1:0] mod3_dec(input logic [1:0] v);
    return (v == 2'd0) ? 2'd2 : v - 2'd1;
  endfunction

  function automatic logic [RING_W-1:0] mod7_inc(input logic [RING_W-1:0] v);
    return (v == RING_W'(RING_ROWS - 1)) ? '0 : v + RING_W'(1);
  endfunction

  function automatic logic [RING_W-1:0] mod7_dec(input logic [RING_W-1:0] v);
    return (v == '0) ? RING_W'(RING_ROWS - 1) : v - RING_W'(1);
  endfunction

endpackage

@@ rtl/hcr_if.sv @@
// Stream interfaces for the pixel input and the response output channels.
// Depends on hcr_pkg.
`timescale 1ns / 1ps
interface hcr_in_if import hcr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;
  logic                  frame_start;
  modport source (output valid, pixel, frame_start, input ready);
  modport sink (input valid, pixel, frame_start, output ready);
endinterface

interface hcr_out_if import hcr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RESP_W-1:0] response;
  logic [COL_W-1:0]  column;
  logic [ROW_W-1:0]  row;
  logic              frame_end;
  modport source (output valid, response, column, row, frame_end, input ready);
  modport sink (input valid, response, column, row, frame_end, output ready);
endinterface

@@ rtl/hcr_front.sv @@
// Front end: accepts pixels, tracks raster position and classifies each request.
// Depends on hcr_pkg and hcr_in_if.
`timescale 1ns / 1ps
module hcr_front import hcr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  hcr_in_if.sink           in_if,
  input  logic [DIM_W-1:0] cfg_width,
  input  logic [DIM_W-1:0] cfg_height,
  input  logic [RAD_W-1:0] cfg_radius,
  input  logic             q_full,
  output logic             q_push,
  output hcr_ent_t         q_ent
);

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [1:0]        m3_r, m3_nxt;
  logic [RING_W-1:0] m7_r, m7_nxt;

  logic [DIM_W-1:0]  wc, hc, c, rw, lim;
  logic [1:0]        m3;
  logic [RING_W-1:0] m7;

  assign in_if.ready = !q_full;
  assign q_push      = in_if.valid && !q_full;

  always_comb begin
    wc = (cfg_width == '0) ? DIM_W'(1) :
         (cfg_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : cfg_width;
    hc = (cfg_height == '0) ? DIM_W'(1) :
         (cfg_height > DIM_W'(HEIGHT_LIM)) ? DIM_W'(HEIGHT_LIM) : cfg_height;
    c  = {1'b0, col_r};
    rw = {1'b0, row_r};
    m3 = m3_r;
    m7 = m7_r;
    if (in_if.frame_start) begin
      c  = '0;
      rw = '0;
      m3 = '0;
      m7 = '0;
    end
    // wrap when a register change leaves the position outside the image
    if (c >= wc) begin
      c  = '0;
      rw = rw + DIM_W'(1);
      m3 = mod3_inc(m3);
      m7 = mod7_inc(m7);
    end
    if (rw >= hc) begin
      rw = '0;
      m3 = '0;
      m7 = '0;
    end
    lim = DIM_W'(2) + DIM_W'({cfg_radius, 1'b0});

    q_ent.pixel = in_if.pixel;
    q_ent.x     = c[COL_W-1:0];
    q_ent.y     = rw[ROW_W-1:0];
    q_ent.r3    = m3;
    q_ent.r7    = m7;
    q_ent.rad   = cfg_radius;
    q_ent.grad  = (c >= DIM_W'(2)) && (rw >= DIM_W'(2));
    q_ent.resp  = (c >= lim) && (rw >= lim);
    q_ent.last  = (c == wc - DIM_W'(1)) && (rw == hc - DIM_W'(1));

    if (c + DIM_W'(1) >= wc) begin
      col_nxt = '0;
      if (rw + DIM_W'(1) >= hc) begin
        row_nxt = '0;
        m3_nxt  = '0;
        m7_nxt  = '0;
      end else begin
        row_nxt = rw[ROW_W-1:0] + ROW_W'(1);
        m3_nxt  = mod3_inc(m3);
        m7_nxt  = mod7_inc(m7);
      end
    end else begin
      col_nxt = c[COL_W-1:0] + COL_W'(1);
      row_nxt = rw[ROW_W-1:0];
      m3_nxt  = m3;
      m7_nxt  = m7;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      m3_r  <= '0;
      m7_r  <= '0;
    end else if (q_push) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      m3_r  <= m3_nxt;
      m7_r  <= m7_nxt;
    end
  end

endmodule

@@ rtl/hcr_fifo.sv @@
// Short request queue between the front end and the back end.
// Depends on hcr_pkg.
`timescale 1ns / 1ps
module hcr_fifo import hcr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  hcr_ent_t push_ent,
  input  logic     pop,
  output hcr_ent_t head,
  output logic     full,
  output logic     empty
);

  hcr_ent_t       mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QAW'(1);
      if (pop)  rp_r <= rp_r + QAW'(1);
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule

@@ rtl/hcr_back.sv @@
// Back end: line stores, Sobel gradients, box sums and the Harris arithmetic.
// Depends on hcr_pkg and hcr_out_if.
`timescale 1ns / 1ps
module hcr_back import hcr_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  hcr_ent_t       q_head,
  output logic           q_pop,
  input  logic [K_W-1:0] cfg_k,
  hcr_out_if.source      out_if
);

  localparam int PIX_AW   = 2 + COL_W;
  localparam int PROD_AW  = RING_W + COL_W;

  hcr_bstate_t st_r, st_nxt;
  hcr_ent_t    ent_r;

  logic [2:0]            cnt_r;
  logic                  rdv_r;
  logic [2:0]            rdi_r;
  logic [PIXEL_BITS-1:0] taps_r [7];
  logic [PIXEL_BITS-1:0] pix_mem [2**PIX_AW];
  logic [PIXEL_BITS-1:0] pix_q_r;
  logic [PIX_AW-1:0]     pix_ra;
  logic                  pix_we;

  logic signed [GRAD_W-1:0] gx_r, gy_r;
  logic [3*PROD_W-1:0]      prod_mem [2**PROD_AW];
  logic [3*PROD_W-1:0]      prod_q_r, prod_wd;
  logic                     prod_we, pv_r;

  logic [RING_W-1:0]   ring_r;
  logic [2:0]          rc_r, cc_r;
  logic [SQ_SUM_W-1:0] sxx_r, syy_r;
  logic [XY_SUM_W-1:0] sxy_r;

  logic [MUL_IN_W-1:0]  mul_a, mul_b, axy, tr;
  logic [MUL_OUT_W-1:0] mul_r;
  logic [2*SQ_SUM_W-1:0] p_r;
  logic [Q_W-1:0]        q_r, pe, d;
  logic [MUL_IN_W-1:0]   t2hi_r;
  logic [KLO_W-1:0]      klo_r;
  logic [RESP_W-1:0]     kt_r, res_r;
  logic [KLO_W+MUL_IN_W:0] ksum;

  logic [1:0]       b3, m3, t3;
  logic [COL_W-1:0] x1, x2;
  logic [2:0]       span;
  logic             out_load;

  logic signed [GRAD_W:0] gx_c, gy_c;
  logic signed [2*GRAD_W-1:0] pxx, pyy, pxy;

  assign b3   = ent_r.r3;
  assign m3   = mod3_dec(ent_r.r3);
  assign t3   = mod3_dec(m3);
  assign x1   = ent_r.x - COL_W'(1);
  assign x2   = ent_r.x - COL_W'(2);
  assign span = {ent_r.rad, 1'b0};

  // pixel taps: 0 t[x], 1 t[x-1], 2 t[x-2], 3 m[x], 4 m[x-2], 5 b[x-1], 6 b[x-2]
  always_comb begin
    case (cnt_r)
      3'd0:    pix_ra = {t3, ent_r.x};
      3'd1:    pix_ra = {t3, x1};
      3'd2:    pix_ra = {t3, x2};
      3'd3:    pix_ra = {m3, ent_r.x};
      3'd4:    pix_ra = {m3, x2};
      3'd5:    pix_ra = {b3, x1};
      default: pix_ra = {b3, x2};
    endcase
  end

  assign pix_we = (st_r == B_PIX) && (cnt_r == 3'd0);

  always_ff @(posedge clk) begin
    if (pix_we) pix_mem[{b3, ent_r.x}] <= ent_r.pixel;
    pix_q_r <= pix_mem[pix_ra];
  end

  always_comb begin
    gx_c = $signed({2'b00, 10'(taps_r[0]) + 10'({taps_r[3], 1'b0}) + 10'(ent_r.pixel)})
         - $signed({2'b00, 10'(taps_r[2]) + 10'({taps_r[4], 1'b0}) + 10'(taps_r[6])});
    gy_c = $signed({2'b00, 10'(taps_r[6]) + 10'({taps_r[5], 1'b0}) + 10'(ent_r.pixel)})
         - $signed({2'b00, 10'(taps_r[2]) + 10'({taps_r[1], 1'b0}) + 10'(taps_r[0])});
    pxx = gx_r * gx_r;
    pyy = gy_r * gy_r;
    pxy = gx_r * gy_r;
    prod_wd = {pxx[PROD_W-1:0], pyy[PROD_W-1:0], pxy[PROD_W-1:0]};
  end

  assign prod_we = (st_r == B_PROD);

  always_ff @(posedge clk) begin
    if (prod_we) prod_mem[{mod7_dec(ent_r.r7), x1}] <= prod_wd;
    prod_q_r <= prod_mem[{ring_r, x1 - COL_W'(cc_r)}];
  end

  // shared multiplier operands
  always_comb begin
    tr  = MUL_IN_W'(sxx_r) + MUL_IN_W'(syy_r);
    axy = sxy_r[XY_SUM_W-1] ? (~sxy_r + XY_SUM_W'(1)) : sxy_r;
    case (st_r)
      B_M1: begin
        mul_a = MUL_IN_W'(sxx_r);
        mul_b = MUL_IN_W'(syy_r);
      end
      B_M2: begin
        mul_a = axy;
        mul_b = axy;
      end
      B_M3: begin
        mul_a = tr;
        mul_b = tr;
      end
      B_M4: begin
        mul_a = mul_r[MUL_IN_W-1:0];
        mul_b = MUL_IN_W'(cfg_k);
      end
      B_M5: begin
        mul_a = t2hi_r;
        mul_b = MUL_IN_W'(cfg_k);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    ksum = {mul_r[KLO_W-1:0], {MUL_IN_W{1'b0}}} + (KLO_W+MUL_IN_W+1)'(klo_r)
         + (KLO_W+MUL_IN_W+1)'(32'h8000);
    pe   = Q_W'(p_r);
    d    = (pe >= q_r) ? (pe - q_r) : (q_r - pe);
  end

  assign out_load = (st_r == B_OUT) && (!out_if.valid || out_if.ready);

  always_comb begin
    st_nxt = st_r;
    q_pop  = 1'b0;
    unique case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop  = 1'b1;
          st_nxt = B_PIX;
        end
      end
      B_PIX: begin
        if (!ent_r.grad) st_nxt = B_IDLE;
        else if (cnt_r == 3'd6) st_nxt = B_PWAIT;
      end
      B_PWAIT: st_nxt = B_GRAD;
      B_GRAD:  st_nxt = B_PROD;
      B_PROD:  st_nxt = ent_r.resp ? B_SUM : B_IDLE;
      B_SUM: begin
        if (cc_r == span && rc_r == span) st_nxt = B_SWAIT;
      end
      B_SWAIT: st_nxt = B_M1;
      B_M1:    st_nxt = B_M2;
      B_M2:    st_nxt = B_M3;
      B_M3:    st_nxt = B_M4;
      B_M4:    st_nxt = B_M5;
      B_M5:    st_nxt = B_M6;
      B_M6:    st_nxt = B_M7;
      B_M7:    st_nxt = B_M8;
      B_M8:    st_nxt = B_OUT;
      B_OUT: begin
        if (out_load) st_nxt = B_IDLE;
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= B_IDLE;
      rdv_r         <= 1'b0;
      pv_r          <= 1'b0;
      out_if.valid  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      rdv_r <= (st_r == B_PIX) && ent_r.grad;
      pv_r  <= (st_r == B_SUM);
      if (out_load) out_if.valid <= 1'b1;
      else if (out_if.ready) out_if.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rdi_r <= cnt_r;
    mul_r <= mul_a * mul_b;
    if (q_pop) ent_r <= q_head;
    if (st_r == B_IDLE) cnt_r <= '0;
    else if (st_r == B_PIX) cnt_r <= cnt_r + 3'd1;
    if (rdv_r) taps_r[rdi_r] <= pix_q_r;
    if (st_r == B_GRAD) begin
      gx_r <= gx_c[GRAD_W-1:0];
      gy_r <= gy_c[GRAD_W-1:0];
    end
    if (st_r == B_PROD) begin
      ring_r <= mod7_dec(ent_r.r7);
      rc_r   <= '0;
      cc_r   <= '0;
      sxx_r  <= '0;
      syy_r  <= '0;
      sxy_r  <= '0;
    end else begin
      if (st_r == B_SUM) begin
        // walk the box one entry a cycle, rows backwards round the ring
        if (cc_r == span) begin
          cc_r   <= '0;
          rc_r   <= rc_r + 3'd1;
          ring_r <= mod7_dec(ring_r);
        end else begin
          cc_r <= cc_r + 3'd1;
        end
      end
      if (pv_r) begin
        sxx_r <= sxx_r + SQ_SUM_W'(prod_q_r[3*PROD_W-1:2*PROD_W]);
        syy_r <= syy_r + SQ_SUM_W'(prod_q_r[2*PROD_W-1:PROD_W]);
        sxy_r <= sxy_r + {{(XY_SUM_W-PROD_W){prod_q_r[PROD_W-1]}},
                          prod_q_r[PROD_W-1:0]};
      end
    end
    if (st_r == B_M2) p_r    <= mul_r[2*SQ_SUM_W-1:0];
    if (st_r == B_M3) q_r    <= Q_W'(mul_r);
    if (st_r == B_M4) t2hi_r <= mul_r[MUL_OUT_W-1:MUL_IN_W];
    if (st_r == B_M5) klo_r  <= mul_r[KLO_W-1:0];
    if (st_r == B_M6) kt_r   <= ksum[KLO_W+MUL_IN_W-1:16];
    if (st_r == B_M7) q_r    <= q_r + Q_W'(kt_r);
    if (st_r == B_M8) res_r  <= (d[Q_W-1:RESP_W] != '0) ? '1 : d[RESP_W-1:0];
    if (out_load) begin
      out_if.response  <= res_r;
      out_if.column    <= ent_r.x - COL_W'(1) - COL_W'(ent_r.rad);
      out_if.row       <= ent_r.y - ROW_W'(1) - ROW_W'(ent_r.rad);
      out_if.frame_end <= ent_r.last;
    end
  end

  a_sum_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_SUM) |-> (rc_r <= span && cc_r <= span))
    else $error("box walk ran past the window");

  a_out_from_fsm: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> $past(st_r == B_OUT))
    else $error("result raised outside the output state");

  a_resp_needs_grad: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_SUM) |-> ent_r.grad)
    else $error("box sum started for a pixel without a gradient");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (st_r == B_PIX))
    else $error("request popped without starting");

endmodule

@@ rtl/harris_corner_response.sv @@
// Harris corner response over a raster stream of 8-bit grey pixels. Each pixel
// request is classified in the front end, queued, and worked off in the back
// end: a pixel without a full Sobel neighbourhood only stores its pixel, one
// with gradients only also stores its products, and one that completes a box
// also sums it, runs the Harris arithmetic and waits for the output to drain.
// Time per pixel is set by the single read port of the pixel and product line
// stores (one tap or box entry a cycle) and by the one shared 27x27 multiplier.
// Results carry the window centre's column and row; frame_end marks the frame's
// last response. Depends on hcr_pkg, hcr_if, hcr_front, hcr_fifo and hcr_back.
`timescale 1ns / 1ps
module harris_corner_response import hcr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  hcr_in_if.sink               in_if,
  hcr_out_if.source            out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [K_W-1:0]   k_r;
  logic [RAD_W-1:0] rad_r;
  logic [DIM_W-1:0] width_r, height_r;

  logic     q_full, q_empty, q_push, q_pop;
  hcr_ent_t q_ent, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r      <= K_W'(2621);
      rad_r    <= RAD_W'(1);
      width_r  <= DIM_W'(640);
      height_r <= DIM_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HARRIS_K:      k_r      <= cfg_data[K_W-1:0];
        CFG_WINDOW_RADIUS: rad_r    <= cfg_data[RAD_W-1:0];
        CFG_IMAGE_WIDTH:   width_r  <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:  height_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  hcr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .cfg_radius (rad_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_ent      (q_ent)
  );

  hcr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (q_ent),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  hcr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .cfg_k   (k_r),
    .out_if  (out_if)
  );

endmodule
